>>> rtl/point_rotation_about_axis_macros.svh
// ---------------------------------------------------------------------------
// point rotation about axis: assertion macros
// Short forms for the concurrent checks; they sample on clock and are
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef POINT_ROTATION_ABOUT_AXIS_MACROS_SVH
`define POINT_ROTATION_ABOUT_AXIS_MACROS_SVH

// same-cycle implication
`define PRAX_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRAX_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/prax_pkg.sv
// ---------------------------------------------------------------------------
// prax_pkg
// Constants, register indexes and fixed-point helpers for the point
// rotation block.
// ---------------------------------------------------------------------------
`default_nettype none

package prax_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 30;
   localparam int SAT_W     = 40;   // widest value that ever gets saturated
   localparam int CSR_IDX_W = 4;

   // settle count that holds req_stall after a register write while the coefficient pipeline settles
   localparam logic [1:0] MAT_SETTLE = 2'd2;

   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_X  = 4'd0,
      CSR_AXIS_Y  = 4'd1,
      CSR_AXIS_Z  = 4'd2,
      CSR_PIVOT_X = 4'd3,
      CSR_PIVOT_Y = 4'd4,
      CSR_PIVOT_Z = 4'd5,
      CSR_COS     = 4'd6,
      CSR_SIN     = 4'd7
   } csr_index_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(32'sh7FFF_FFFF);
      lo = SAT_W'(32'sh8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[WORD_W-1:0];
   endfunction

   // floor((a * b) / 2^30), kept to 34 bits
   function automatic logic signed [33:0] qmul_wide(input logic signed [WORD_W-1:0] a,
                                                    input logic signed [WORD_W-1:0] b);
      logic signed [63:0] p;
      logic signed [63:0] s;
      p = 64'(a) * 64'(b);
      s = p >>> FRAC_BITS;
      return s[33:0];
   endfunction

   // floor((a * b) / 2^30) saturated to 32 bits
   function automatic logic signed [WORD_W-1:0] qmul_sat(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
      logic signed [33:0] q;
      q = qmul_wide(a, b);
      return sat_word(SAT_W'(q));
   endfunction

   // floor((omc * u) / 2^30) with a 34-bit omc, kept to 36 bits
   function automatic logic signed [35:0] omc_term(input logic signed [33:0] omc,
                                                   input logic signed [WORD_W-1:0] u);
      logic signed [65:0] p;
      logic signed [65:0] s;
      p = 66'(omc) * 66'(u);
      s = p >>> FRAC_BITS;
      return s[35:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/point_rotation_about_axis.sv
// ---------------------------------------------------------------------------
// point_rotation_about_axis
// Rotates Q16.16 points about an axis through a pivot with the axis-angle
// matrix built from the axis, cosine and sine registers.
// ---------------------------------------------------------------------------
// Usage
//   req_*: one point word per accepted cycle (req_valid high, req_stall low).
//   rsp_*: one rotated point word per input word, in order; the receiver
//          holds rsp_stall high to keep the word on the port.
//   csr_*: register writes, index 0..7 = axis x/y/z, pivot x/y/z, cos, sin;
//          csr_ready is always high, other indexes are dropped.
// Throughput is one word per cycle while req_stall and rsp_stall stay low. A result
// passes on to rsp_* through capture, subtract pivot, nine multipliers, row sums
// and shift/add pivot/saturate into the output register, each stage registered.
// The nine matrix coefficients come from a separate three-stage pipeline fed
// by the registers; after reset and after every register write req_stall is
// held high while it settles.
// Reset restores the identity rotation about the z axis through the origin
// and empties the pipeline.
// A stalled receiver fills empty stages first; its stall reaches req_stall only
// once every stage holds a word.
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_rotation_about_axis_macros.svh"

module point_rotation_about_axis
   import prax_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic signed [WORD_W-1:0]    req_point_x,
   input  wire logic signed [WORD_W-1:0]    req_point_y,
   input  wire logic signed [WORD_W-1:0]    req_point_z,

   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic signed [WORD_W-1:0]    rsp_rotated_x,
   output      logic signed [WORD_W-1:0]    rsp_rotated_y,
   output      logic signed [WORD_W-1:0]    rsp_rotated_z,

   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [WORD_W-1:0]           csr_data
);

   // registers
   logic signed [WORD_W-1:0] axis_x_ff, axis_y_ff, axis_z_ff;
   logic signed [WORD_W-1:0] pivot_x_ff, pivot_y_ff, pivot_z_ff;
   logic signed [WORD_W-1:0] cos_ff, sin_ff;
   logic [1:0]               settle_ff;
   logic [1:0]               settle_in;
   logic                     csr_write;

   // coefficient pipeline
   logic signed [WORD_W-1:0] uxx_ff, uyy_ff, uzz_ff, uxy_ff, uxz_ff, uyz_ff;
   logic signed [33:0]       sx_ff, sy_ff, sz_ff, omc_ff;
   logic signed [33:0]       omc_in;
   logic signed [35:0]       txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff;
   logic signed [WORD_W-1:0] m_ff [3][3];
   logic signed [WORD_W-1:0] m_in [3][3];

   // point pipeline
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                     rsp_valid_ff;
   logic                     s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
   logic                     req_take;
   logic signed [WORD_W-1:0] p_ff [3];
   logic signed [WORD_W-1:0] pivot [3];
   logic signed [WORD_W:0]   d_ff [3];
   logic signed [WORD_W:0]   d_in [3];
   logic signed [64:0]       prod_ff [3][3];
   logic signed [64:0]       prod_in [3][3];
   logic signed [66:0]       sum_ff [3];
   logic signed [66:0]       sum_in [3];
   logic signed [WORD_W-1:0] rot_ff [3];
   logic signed [WORD_W-1:0] rot_in [3];

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff  <= '0;
         axis_y_ff  <= '0;
         axis_z_ff  <= 32'sh4000_0000;
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         pivot_z_ff <= '0;
         cos_ff     <= 32'sh4000_0000;
         sin_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AXIS_X:  axis_x_ff  <= csr_data;
            CSR_AXIS_Y:  axis_y_ff  <= csr_data;
            CSR_AXIS_Z:  axis_z_ff  <= csr_data;
            CSR_PIVOT_X: pivot_x_ff <= csr_data;
            CSR_PIVOT_Y: pivot_y_ff <= csr_data;
            CSR_PIVOT_Z: pivot_z_ff <= csr_data;
            CSR_COS:     cos_ff     <= csr_data;
            CSR_SIN:     sin_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      settle_in = settle_ff;
      if (csr_write) begin
         settle_in = MAT_SETTLE;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= MAT_SETTLE;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // ------------------------------------------------------ coefficient pipeline
   assign omc_in = ONE_Q30 - 34'(cos_ff);

   // pair products and sine terms
   always_ff @(posedge clock) begin
      uxx_ff <= qmul_sat(axis_x_ff, axis_x_ff);
      uyy_ff <= qmul_sat(axis_y_ff, axis_y_ff);
      uzz_ff <= qmul_sat(axis_z_ff, axis_z_ff);
      uxy_ff <= qmul_sat(axis_x_ff, axis_y_ff);
      uxz_ff <= qmul_sat(axis_x_ff, axis_z_ff);
      uyz_ff <= qmul_sat(axis_y_ff, axis_z_ff);
      sx_ff  <= qmul_wide(sin_ff, axis_x_ff);
      sy_ff  <= qmul_wide(sin_ff, axis_y_ff);
      sz_ff  <= qmul_wide(sin_ff, axis_z_ff);
      omc_ff <= omc_in;
   end

   // (1 - cos) scaled pair products
   always_ff @(posedge clock) begin
      txx_ff <= omc_term(omc_ff, uxx_ff);
      tyy_ff <= omc_term(omc_ff, uyy_ff);
      tzz_ff <= omc_term(omc_ff, uzz_ff);
      txy_ff <= omc_term(omc_ff, uxy_ff);
      txz_ff <= omc_term(omc_ff, uxz_ff);
      tyz_ff <= omc_term(omc_ff, uyz_ff);
   end

   always_comb begin
      m_in[0][0] = sat_word(SAT_W'(txx_ff) + SAT_W'(cos_ff));
      m_in[0][1] = sat_word(SAT_W'(txy_ff) - SAT_W'(sz_ff));
      m_in[0][2] = sat_word(SAT_W'(txz_ff) + SAT_W'(sy_ff));
      m_in[1][0] = sat_word(SAT_W'(txy_ff) + SAT_W'(sz_ff));
      m_in[1][1] = sat_word(SAT_W'(tyy_ff) + SAT_W'(cos_ff));
      m_in[1][2] = sat_word(SAT_W'(tyz_ff) - SAT_W'(sx_ff));
      m_in[2][0] = sat_word(SAT_W'(txz_ff) - SAT_W'(sy_ff));
      m_in[2][1] = sat_word(SAT_W'(tyz_ff) + SAT_W'(sx_ff));
      m_in[2][2] = sat_word(SAT_W'(tzz_ff) + SAT_W'(cos_ff));
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   // ------------------------------------------------------------ point pipeline
   // a stage loads when it is empty or the one after it moves
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_stall = reset || (settle_ff != 2'd0) || !s1_ready;
   assign req_take  = req_valid && !req_stall;

   assign pivot[0] = pivot_x_ff;
   assign pivot[1] = pivot_y_ff;
   assign pivot[2] = pivot_z_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = 33'(p_ff[k]) - 33'(pivot[k]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = 65'(m_ff[r][k]) * 65'(d_ff[k]);
         end
      end
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = 67'(prod_ff[r][0]) + 67'(prod_ff[r][1]) + 67'(prod_ff[r][2]);
      end
      for (int r = 0; r < 3; r++) begin
         // exact sum, floor shift, then back to the pivot frame
         rot_in[r] = sat_word(SAT_W'(sum_ff[r] >>> FRAC_BITS) + SAT_W'(pivot[r]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_take;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         p_ff[0] <= req_point_x;
         p_ff[1] <= req_point_y;
         p_ff[2] <= req_point_z;
      end
      if (s2_ready) begin
         d_ff <= d_in;
      end
      if (s3_ready) begin
         prod_ff <= prod_in;
      end
      if (s4_ready) begin
         sum_ff <= sum_in;
      end
      if (out_ready) begin
         rot_ff <= rot_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rotated_x = rot_ff[0];
   assign rsp_rotated_y = rot_ff[1];
   assign rsp_rotated_z = rot_ff[2];

   // ---------------------------------------------------------------- checks
   `PRAX_ASSERT_NXT(a_csr_holds_req, csr_write, req_stall, "point taken before coefficients settled")
   `PRAX_ASSERT_IMP(a_rsp_from_s4, $rose(rsp_valid_ff), $past(s4_valid_ff), "result word with no source")
   `PRAX_ASSERT_NXT(a_s4_holds, s4_valid_ff && rsp_valid_ff && rsp_stall, s4_valid_ff, "word lost in last stage")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: point_rotation_about_axis
// Streams Q16.16 points through the block under several axis, pivot and
// angle settings, predicts every rotated point in exact wide arithmetic with
// floor shifts and saturation, and compares each result word field by field.
// Sender bursts and receiver stalls are random; one stretch holds the result
// port off long enough to back the pipeline up into the input.
// ---------------------------------------------------------------------------

module testbench;
   import prax_pkg::*;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [127:0]      wide_type;
   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } point_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   localparam word_type Q30_ONE   = 32'sh4000_0000;
   localparam word_type Q16_ONE   = 32'sh0001_0000;
   localparam word_type WORD_MAX  = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN  = 32'sh8000_0000;
   localparam word_type DIAG_UNIT = 32'sd619925132;   // 1/sqrt(3) in Q1.30
   localparam word_type COS_45    = 32'sd759250125;
   localparam word_type COS_30    = 32'sd929887697;
   localparam word_type SIN_30    = 32'sd536870912;

   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_POINTS  = 170;
   localparam int FLOOD_POINTS  = 48;
   localparam int HOLDOFF_SPAN  = 80;
   localparam int SETTLE_CYCLES = 20;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   word_type               req_point_x   = '0;
   word_type               req_point_y   = '0;
   word_type               req_point_z   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   word_type               rsp_rotated_x;
   word_type               rsp_rotated_y;
   word_type               rsp_rotated_z;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index     = '0;
   logic [WORD_W-1:0]      csr_data      = '0;

   // shadow of the rotation registers
   word_type axis_u  [3] = '{'0, '0, Q30_ONE};
   word_type pivot_q [3] = '{'0, '0, '0};
   word_type cos_v       = Q30_ONE;
   word_type sin_v       = '0;

   point_type      pending_rotations [$];
   int             mismatch_count = 0;
   int             holdoff_left   = 0;
   int             burst_left     = 0;
   bit             pacing_on      = 1'b1;
   stall_mode_type stall_mode     = STALL_NONE;
   int             stall_span     = 0;
   int             stall_tick     = 0;

   point_rotation_about_axis dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .rsp_rotated_z (rsp_rotated_z),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic word_type clamp_word(wide_type v);
      if (v > wide_type'(WORD_MAX)) return WORD_MAX;
      if (v < wide_type'(WORD_MIN)) return WORD_MIN;
      return v[WORD_W-1:0];
   endfunction

   function automatic wide_type q30_mul(wide_type a, wide_type b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic point_type rotate_point(point_type p);
      wide_type  omc;
      wide_type  term [3][3];
      wide_type  sin_u [3];
      wide_type  m [3][3];
      wide_type  d [3];
      wide_type  sum;
      word_type  pin [3];
      word_type  r [3];
      point_type res;
      int        a;
      int        b;
      pin = '{p.x, p.y, p.z};
      omc = wide_type'(Q30_ONE) - wide_type'(cos_v);
      for (a = 0; a < 3; a++) begin
         for (b = a; b < 3; b++) begin
            term[a][b] = q30_mul(omc, clamp_word(q30_mul(axis_u[a], axis_u[b])));
         end
         sin_u[a] = q30_mul(sin_v, axis_u[a]);
         m[a][a] = clamp_word(wide_type'(cos_v) + term[a][a]);
         d[a] = wide_type'(pin[a]) - wide_type'(pivot_q[a]);
      end
      m[0][1] = clamp_word(term[0][1] - sin_u[2]);
      m[0][2] = clamp_word(term[0][2] + sin_u[1]);
      m[1][0] = clamp_word(term[0][1] + sin_u[2]);
      m[1][2] = clamp_word(term[1][2] - sin_u[0]);
      m[2][0] = clamp_word(term[0][2] - sin_u[1]);
      m[2][1] = clamp_word(term[1][2] + sin_u[0]);
      // row sums kept exact, one floor shift at the end
      for (a = 0; a < 3; a++) begin
         sum = m[a][0] * d[0] + m[a][1] * d[1] + m[a][2] * d[2];
         r[a] = clamp_word((sum >>> FRAC_BITS) + wide_type'(pivot_q[a]));
      end
      res.x = r[0];
      res.y = r[1];
      res.z = r[2];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left = holdoff_left - 1;
      end else begin
         if (stall_span == 0) begin
            stall_mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
            stall_span = $urandom_range(10, 150);
         end
         stall_span = stall_span - 1;
         stall_tick = stall_tick + 1;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= ((stall_tick % 5) < 2);
         endcase
      end
   end

   task automatic check_field(string name, word_type want, word_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_result
      point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rotations.size() == 0) begin
            $error("rotated point word with no point outstanding");
            mismatch_count++;
         end else begin
            want = pending_rotations.pop_front();
            check_field("rotated_x", want.x, rsp_rotated_x);
            check_field("rotated_y", want.y, rsp_rotated_y);
            check_field("rotated_z", want.z, rsp_rotated_z);
         end
      end
   end

   // ------------------------------------------------------------------------
   // point and register side
   // ------------------------------------------------------------------------
   task automatic send_point(word_type x, word_type y, word_type z);
      point_type pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall);
      pending_rotations.push_back(rotate_point(pt));
      if (pacing_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
         end
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_rotations.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_AXIS_X:  axis_u[0]  = data;
         CSR_AXIS_Y:  axis_u[1]  = data;
         CSR_AXIS_Z:  axis_u[2]  = data;
         CSR_PIVOT_X: pivot_q[0] = data;
         CSR_PIVOT_Y: pivot_q[1] = data;
         CSR_PIVOT_Z: pivot_q[2] = data;
         CSR_COS:     cos_v      = data;
         CSR_SIN:     sin_v      = data;
         default:     ;
      endcase
   endtask

   task automatic load_rotation(word_type ax, word_type ay, word_type az,
                                word_type px, word_type py, word_type pz,
                                word_type c, word_type s);
      wait_for_results();
      write_reg(CSR_AXIS_X, ax);
      write_reg(CSR_AXIS_Y, ay);
      write_reg(CSR_AXIS_Z, az);
      write_reg(CSR_PIVOT_X, px);
      write_reg(CSR_PIVOT_Y, py);
      write_reg(CSR_PIVOT_Z, pz);
      write_reg(CSR_COS, c);
      write_reg(CSR_SIN, s);
      // indexes past the last register must be dropped
      write_reg(CSR_IDX_W'($urandom_range(int'(CSR_SIN) + 1, (1 << CSR_IDX_W) - 1)),
                $urandom);
      csr_valid <= 1'b0;
   endtask

   function automatic word_type rand_q30();
      return word_type'($urandom_range(0, 32'h8000_0000)) - Q30_ONE;
   endfunction

   function automatic word_type rand_coord();
      case ($urandom_range(0, 3))
         0: return word_type'($urandom_range(0, 1 << 24)) - (1 << 23);
         1: begin
            case ($urandom_range(0, 3))
               0:       return WORD_MAX;
               1:       return WORD_MIN;
               2:       return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic random_rotation();
      word_type ax;
      word_type ay;
      word_type az;
      word_type c;
      word_type s;
      word_type unit;
      unit = $urandom_range(0, 1) ? Q30_ONE : -Q30_ONE;
      case ($urandom_range(0, 3))
         0: begin
            ax = '0;
            ay = '0;
            az = '0;
            case ($urandom_range(0, 2))
               0:       ax = unit;
               1:       ay = unit;
               default: az = unit;
            endcase
         end
         1: begin
            ax = $urandom_range(0, 1) ? DIAG_UNIT : -DIAG_UNIT;
            ay = $urandom_range(0, 1) ? DIAG_UNIT : -DIAG_UNIT;
            az = $urandom_range(0, 1) ? DIAG_UNIT : -DIAG_UNIT;
         end
         2: begin
            ax = rand_q30();
            ay = rand_q30();
            az = rand_q30();
         end
         default: begin
            ax = $urandom;
            ay = $urandom;
            az = $urandom;
         end
      endcase
      case ($urandom_range(0, 3))
         0, 1: begin
            case ($urandom_range(0, 4))
               0: begin c = Q30_ONE; s = '0;      end
               1: begin c = '0;      s = Q30_ONE; end
               2: begin c = COS_45;  s = COS_45;  end
               3: begin c = COS_30;  s = SIN_30;  end
               default: begin c = SIN_30; s = COS_30; end
            endcase
            if ($urandom_range(0, 1)) c = -c;
            if ($urandom_range(0, 1)) s = -s;
         end
         2: begin
            c = rand_q30();
            s = rand_q30();
         end
         default: begin
            c = $urandom;
            s = $urandom;
         end
      endcase
      load_rotation(ax, ay, az, rand_coord(), rand_coord(), rand_coord(), c, s);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_identity_extremes();
      send_point(WORD_MAX, WORD_MIN, -1);
      send_point('0, '0, '0);
      send_point(WORD_MIN, WORD_MAX, 1);
      send_point(32'sh5555_5555, 32'shAAAA_AAAA, Q16_ONE);
   endtask

   task automatic test_quarter_turn_z();
      load_rotation('0, '0, Q30_ONE, 3 * Q16_ONE, -5 * Q16_ONE, '0, '0, Q30_ONE);
      send_point(WORD_MAX, WORD_MAX, WORD_MIN);
      send_point(WORD_MIN, WORD_MIN, WORD_MAX);
      send_point(2 * Q16_ONE, '0, Q16_ONE);
   endtask

   // pivot at the corners makes the offsets span the full 33 bits
   task automatic test_half_turn_far_pivot();
      load_rotation(Q30_ONE, '0, '0, WORD_MAX, WORD_MIN, WORD_MAX, -Q30_ONE, '0);
      send_point(WORD_MIN, WORD_MAX, WORD_MIN);
      send_point(WORD_MAX, WORD_MIN, WORD_MAX);
   endtask

   // axis far from unit length, coefficients saturate
   task automatic test_unnormalized_axis();
      load_rotation(WORD_MAX, WORD_MAX, WORD_MAX, '0, '0, '0, WORD_MIN, WORD_MAX);
      send_point(WORD_MAX, WORD_MIN, WORD_MAX);
      send_point(32'sh1234_5678, -Q16_ONE, WORD_MIN);
      load_rotation(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, Q16_ONE, WORD_MAX, WORD_MIN);
      send_point(WORD_MIN, WORD_MIN, WORD_MIN);
      send_point(WORD_MAX, '0, -1);
   endtask

   task automatic test_oblique_axis();
      load_rotation(DIAG_UNIT, DIAG_UNIT, DIAG_UNIT, 7 * Q16_ONE, -2 * Q16_ONE, Q16_ONE,
                    COS_30, SIN_30);
      send_point(Q16_ONE, '0, '0);
      send_point('0, 10 * Q16_ONE, '0);
      send_point(-Q16_ONE, -Q16_ONE, 100 * Q16_ONE);
   endtask

   task automatic test_random_rotations();
      repeat (RANDOM_PHASES) begin
         random_rotation();
         repeat (PHASE_POINTS) send_point(rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   task automatic test_output_backpressure();
      pacing_on = 1'b0;
      holdoff_left = HOLDOFF_SPAN;
      repeat (FLOOD_POINTS) send_point(rand_coord(), rand_coord(), rand_coord());
      pacing_on = 1'b1;
   endtask

   task automatic test_pause_for_results();
      repeat (3) begin
         repeat ($urandom_range(10, 40)) send_point(rand_coord(), rand_coord(), rand_coord());
         wait_for_results();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_identity_extremes();
      test_quarter_turn_z();
      test_half_turn_far_pivot();
      test_unnormalized_axis();
      test_oblique_axis();
      test_random_rotations();
      test_output_backpressure();
      test_pause_for_results();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
